// File: rtl/srtdd_pkg.sv
package srtdd_pkg;

    localparam int WORD_W = 32;

    typedef struct packed {
        logic signed [WORD_W-1:0] value_in;
        logic                     last_in;
    } t_in;

    typedef struct packed {
        logic signed [WORD_W-1:0] value_out;
        logic                     last_out;
        logic                     dropped;
    } t_out;

    // what a cell shows its neighbors
    typedef struct packed {
        logic                     valid;
        logic                     gt;
        logic signed [WORD_W-1:0] value;
    } t_link;

endpackage

// File: rtl/srtdd_cell.sv
module srtdd_cell
    import srtdd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_ins,
    input  logic                     i_shift,
    input  logic signed [WORD_W-1:0] i_value,
    input  t_link                    i_left,
    input  t_link                    i_right,
    output t_link                    o_link
);

    logic                     r_valid;
    logic signed [WORD_W-1:0] r_value;
    logic                     n_valid;
    logic signed [WORD_W-1:0] n_value;
    logic                     w_gt;

    // an empty cell counts as greater than any value
    assign w_gt = !r_valid || (r_value > i_value);

    assign o_link.valid = r_valid;
    assign o_link.gt    = w_gt;
    assign o_link.value = r_value;

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_ins) begin
            if (i_left.gt) begin
                n_valid = i_left.valid;
                n_value = i_left.value;
            end else if (w_gt) begin
                n_valid = 1'b1;
                n_value = i_value;
            end
        end else if (i_shift) begin
            n_valid = i_right.valid;
            n_value = i_right.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
    end

endmodule

// File: rtl/sort_and_deduplicate.sv
// sort_and_deduplicate
// Input channel (i_valid / o_stall / i_data) takes one signed value per beat;
// last_in marks the final beat of a set. Each beat is inserted into a sorted
// row of MAX_ITEMS cells when taken, so loading runs at one beat per cycle.
// Beats past MAX_ITEMS are discarded and dropped is set on every result of
// that set.
// After the marked beat o_stall rises and the row shifts toward its head one
// cell per cycle unless the receiver stalls a held result. The head cell is
// sent out (o_valid / i_stall / o_data) unless the next cell holds the same
// value, so each distinct value appears once, ascending, with last_out on the
// final one. Draining shifts the row once per stored value; the first result
// waits until the repeats of the lowest value have shifted past the head.
// When the row is drained o_stall falls and the next set may load while the
// final result still waits in the output register.
// While the receiver stalls a held beat, the output register keeps it and the
// row does not shift.
// Reset empties the row and clears the count, overflow flag and output valid.
module sort_and_deduplicate
    import srtdd_pkg::*;
#(
    parameter int MAX_ITEMS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam logic ST_LOAD  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic             r_state;
    logic [CNT_W-1:0] r_count;
    logic             r_ovf;
    logic             r_out_valid;
    t_out             r_out;

    logic  w_in_beat;
    logic  w_room;
    logic  w_ins;
    logic  w_advance;
    logic  w_emit;
    logic  w_end;
    t_link w_link [MAX_ITEMS];

    assign o_stall   = (r_state == ST_DRAIN);
    assign w_in_beat = i_valid && !o_stall;
    assign w_room    = (r_count < CNT_W'(MAX_ITEMS));
    assign w_ins     = w_in_beat && w_room;
    assign w_advance = (r_state == ST_DRAIN) && (!r_out_valid || !i_stall);

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
            t_link w_left;
            t_link w_right;
            if (gi == 0) begin : g_head
                assign w_left = '0;
            end else begin : g_mid
                assign w_left = w_link[gi-1];
            end
            if (gi == MAX_ITEMS - 1) begin : g_tail
                assign w_right = '0;
            end else begin : g_body
                assign w_right = w_link[gi+1];
            end
            srtdd_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ins   (w_ins),
                .i_shift (w_advance),
                .i_value (i_data.value_in),
                .i_left  (w_left),
                .i_right (w_right),
                .o_link  (w_link[gi])
            );
        end
    endgenerate

    assign w_end  = !w_link[1].valid;
    assign w_emit = w_link[0].valid && (w_end || (w_link[1].value != w_link[0].value));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_LOAD: begin
                    if (w_in_beat) begin
                        if (w_room) begin
                            r_count <= r_count + CNT_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_data.last_in) begin
                            r_state <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN: begin
                    if (w_advance && w_end) begin
                        r_state <= ST_LOAD;
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
            if (w_advance) begin
                r_out_valid <= w_emit;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_advance) begin
            r_out.value_out <= w_link[0].value;
            r_out.last_out  <= w_end;
            r_out.dropped   <= r_ovf;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// File: rtl/srtdd_checker.sv
module srtdd_checker
    import srtdd_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input t_in  i_data,
    input logic o_valid,
    input logic i_stall,
    input t_out o_data
);

    logic                     r_prev_valid;
    logic signed [WORD_W-1:0] r_prev;
    logic                     w_out_beat;

    assign w_out_beat = o_valid && !i_stall;

    // last value sent in the current set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_valid <= 1'b0;
        end else if (w_out_beat) begin
            r_prev_valid <= !o_data.last_out;
        end
        if (w_out_beat) begin
            r_prev <= o_data.value_out;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output beat changed while stalled");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_data))
        else $error("input beat changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output not idle after reset");

    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_beat && r_prev_valid |-> o_data.value_out > r_prev)
        else $error("results not strictly ascending");

    a_drain_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.last_out |-> o_stall)
        else $error("input open while a set is still draining");

endmodule

bind sort_and_deduplicate srtdd_checker u_srtdd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
